@@ design/lcpc_pkg.sv @@
// shared types, constants and helper functions for the card number checker
// no dependencies; used by every other file in the design folder
package lcpc_pkg;

    localparam int NUM_W         = 64;
    localparam int DIGITS        = 20;
    localparam int DIG_W         = 4;
    localparam int BITS_PER_STEP = 3;
    localparam int SH_W          = ((NUM_W + BITS_PER_STEP - 1) / BITS_PER_STEP) * BITS_PER_STEP;
    localparam int STEPS         = SH_W / BITS_PER_STEP;
    localparam int GROUP         = 4;
    localparam int NGROUPS       = DIGITS / GROUP;
    localparam int PART_W        = 6;
    localparam int SUM_W         = 8;

    localparam logic [1:0] CLASS_A       = 2'd0;
    localparam logic [1:0] CLASS_B       = 2'd1;
    localparam logic [1:0] CLASS_C       = 2'd2;
    localparam logic [1:0] CLASS_INVALID = 2'd3;

    typedef logic [DIGITS-1:0][DIG_W-1:0] t_digits;

    typedef struct packed {
        logic clr;
        logic step;
    } t_cell_ctl;

    typedef struct packed {
        logic [1:0] class_code;
        logic       checksum_ok;
        logic       card_accepted;
    } t_result;

    // luhn contribution of one bcd digit, doubled digits fold back above nine
    function automatic logic [DIG_W-1:0] luhn_term(input logic [DIG_W-1:0] d,
                                                    input logic dbl);
        logic [DIG_W:0] t;
        t = dbl ? {d, 1'b0} : {1'b0, d};
        if (t > 5'd9) begin
            t = t - 5'd9;
        end
        return t[DIG_W-1:0];
    endfunction

    // true when the digit sum is a multiple of ten
    function automatic logic is_mult10(input logic [SUM_W-1:0] s);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * 10 < (1 << SUM_W); k++) begin
            hit = hit | (s == SUM_W'(k * 10));
        end
        return hit;
    endfunction

endpackage

@@ design/lcpc_cell.sv @@
// one bcd digit cell of the binary-to-decimal shift chain
// depends on lcpc_pkg; instantiated in a row by luhn_check_prefix_class_top
module lcpc_cell (
    input  logic                                i_clk,
    input  lcpc_pkg::t_cell_ctl                 i_ctl,
    input  logic [lcpc_pkg::BITS_PER_STEP-1:0]  i_bits,
    output logic [lcpc_pkg::BITS_PER_STEP-1:0]  o_bits,
    output logic [lcpc_pkg::DIG_W-1:0]          o_digit
);

    logic [lcpc_pkg::DIG_W-1:0] r_digit;
    logic [lcpc_pkg::DIG_W-1:0] n_digit;

    // several add-3-then-shift steps per clock while i_ctl.step is set, bit s comes from the lower cell's step s
    always_comb begin
        n_digit = r_digit;
        o_bits  = '0;
        for (int s = 0; s < lcpc_pkg::BITS_PER_STEP; s++) begin
            if (n_digit >= 4'd5) begin
                n_digit = n_digit + 4'd3;
            end
            o_bits[s] = n_digit[lcpc_pkg::DIG_W-1];
            n_digit   = {n_digit[lcpc_pkg::DIG_W-2:0], i_bits[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_digit <= '0;
        end else if (i_ctl.step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

@@ design/lcpc_reduce.sv @@
// luhn digit sum over the bcd digits and leading-digit classing
// depends on lcpc_pkg; fed by the cell row in luhn_check_prefix_class_top
module lcpc_reduce (
    input  logic              i_clk,
    input  logic              i_en,
    input  lcpc_pkg::t_digits i_digits,
    output lcpc_pkg::t_result o_result
);

    logic [lcpc_pkg::NGROUPS-1:0][lcpc_pkg::PART_W-1:0] r_part;
    logic [lcpc_pkg::NGROUPS-1:0][lcpc_pkg::PART_W-1:0] n_part;
    logic [lcpc_pkg::SUM_W-1:0]                         w_sum;
    logic                                               w_ok;
    logic                                               w_z13;
    logic                                               w_z15;
    logic                                               w_z16;
    logic                                               w_cls_a;
    logic                                               w_cls_b;
    logic                                               w_cls_c;
    logic [1:0]                                         w_class;

    // first level: groups of four terms, odd positions from the right doubled
    always_comb begin
        for (int g = 0; g < lcpc_pkg::NGROUPS; g++) begin
            n_part[g] = '0;
            for (int j = 0; j < lcpc_pkg::GROUP; j++) begin
                n_part[g] = n_part[g] + lcpc_pkg::PART_W'(lcpc_pkg::luhn_term(
                    i_digits[g*lcpc_pkg::GROUP+j], 1'((g*lcpc_pkg::GROUP+j) % 2)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_part <= n_part;
        end
    end

    always_comb begin
        w_sum = '0;
        for (int g = 0; g < lcpc_pkg::NGROUPS; g++) begin
            w_sum = w_sum + lcpc_pkg::SUM_W'(r_part[g]);
        end
    end

    assign w_ok = lcpc_pkg::is_mult10(w_sum);

    // prefix tests straight on the decimal digits
    assign w_z16 = (i_digits[19:16] == '0);
    assign w_z15 = w_z16 && (i_digits[15] == 4'd0);
    assign w_z13 = w_z15 && (i_digits[14] == 4'd0) && (i_digits[13] == 4'd0);

    assign w_cls_a = w_z15 && (i_digits[14] == 4'd3)
                     && ((i_digits[13] == 4'd4) || (i_digits[13] == 4'd7));
    assign w_cls_b = w_z16 && (i_digits[15] == 4'd5)
                     && (i_digits[14] >= 4'd1) && (i_digits[14] <= 4'd5);
    assign w_cls_c = (w_z13 && (i_digits[12] == 4'd4))
                     || (w_z16 && (i_digits[15] == 4'd4));

    always_comb begin
        if (!w_ok) begin
            w_class = lcpc_pkg::CLASS_INVALID;
        end else if (w_cls_a) begin
            w_class = lcpc_pkg::CLASS_A;
        end else if (w_cls_b) begin
            w_class = lcpc_pkg::CLASS_B;
        end else if (w_cls_c) begin
            w_class = lcpc_pkg::CLASS_C;
        end else begin
            w_class = lcpc_pkg::CLASS_INVALID;
        end
    end

    assign o_result.class_code    = w_class;
    assign o_result.checksum_ok   = w_ok;
    assign o_result.card_accepted = (w_class != lcpc_pkg::CLASS_INVALID);

endmodule

@@ design/luhn_check_prefix_class_top.sv @@
// Card number checker: one 64-bit account number per transfer in, one result per transfer out.
// The number is turned into 20 decimal digits by a row of digit cells that take three binary
// bits per clock in S_CONV, then S_RED registers the luhn terms summed in groups of four and
// S_FIN finishes the sum, the mod-10 test and the prefix class into the output register.
// An item passes through S_CONV, S_RED and S_FIN after its transfer; once S_FIN has loaded
// the output register, the block returns to S_IDLE and takes the next input even if that
// result is still waiting on the output side; it holds in S_FIN only while an older result
// has not been taken. Depends on lcpc_pkg, lcpc_cell and lcpc_reduce.
module luhn_check_prefix_class_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [lcpc_pkg::NUM_W-1:0] i_account_number,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [1:0]                 o_class_code,
    output logic                       o_checksum_ok,
    output logic                       o_card_accepted
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;
    localparam int         CNT_W  = $clog2(lcpc_pkg::STEPS);

    logic [1:0]                 r_state;
    logic [1:0]                 n_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [lcpc_pkg::SH_W-1:0]  r_sh;
    logic                       r_o_valid;
    lcpc_pkg::t_result          r_out;
    logic                       w_in_xfer;
    logic                       w_load;
    lcpc_pkg::t_cell_ctl        w_ctl;
    lcpc_pkg::t_digits          w_digits;
    lcpc_pkg::t_result          w_result;
    logic [lcpc_pkg::BITS_PER_STEP-1:0] w_feed;
    logic [lcpc_pkg::BITS_PER_STEP-1:0] w_bits [lcpc_pkg::DIGITS+1];

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_xfer = i_valid && !o_stall;
    assign w_load    = (r_state == S_FIN) && (!r_o_valid || !i_stall);

    assign w_ctl.clr  = w_in_xfer;
    assign w_ctl.step = (r_state == S_CONV);

    // lowest cell takes the msbs of the number first
    always_comb begin
        for (int s = 0; s < lcpc_pkg::BITS_PER_STEP; s++) begin
            w_feed[s] = r_sh[lcpc_pkg::SH_W-1-s];
        end
    end

    assign w_bits[0] = w_feed;

    for (genvar i = 0; i < lcpc_pkg::DIGITS; i++) begin : g_cell
        lcpc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_bits  (w_bits[i]),
            .o_bits  (w_bits[i+1]),
            .o_digit (w_digits[i])
        );
    end

    lcpc_reduce u_reduce (
        .i_clk    (i_clk),
        .i_en     (r_state == S_RED),
        .i_digits (w_digits),
        .o_result (w_result)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_xfer) n_state = S_CONV;
            S_CONV: if (r_cnt == CNT_W'(lcpc_pkg::STEPS - 1)) n_state = S_RED;
            S_RED:  n_state = S_FIN;
            S_FIN:  if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer) begin
                r_cnt <= '0;
            end else if (r_state == S_CONV) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_sh <= lcpc_pkg::SH_W'(i_account_number);
        end else if (r_state == S_CONV) begin
            r_sh <= r_sh << lcpc_pkg::BITS_PER_STEP;
        end
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_class_code    = r_out.class_code;
    assign o_checksum_ok   = r_out.checksum_ok;
    assign o_card_accepted = r_out.card_accepted;

    // twenty digits always hold a 64-bit value, nothing leaves the top cell
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) |-> (w_bits[lcpc_pkg::DIGITS] == '0))
        else $error("digit chain overflow");

    a_rise_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_FIN))
        else $error("result shown without finishing pass");

    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_card_accepted == (o_class_code != lcpc_pkg::CLASS_INVALID)))
        else $error("accepted flag disagrees with class");

    a_bad_sum_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_checksum_ok) |-> (o_class_code == lcpc_pkg::CLASS_INVALID))
        else $error("class given to number with bad checksum");

    a_start_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_CONV) && (r_cnt == '0))
        else $error("conversion did not start after input transfer");

endmodule
